>>> rtl/bitmap_text_renderer_macros.svh
// Assertion macros used by the bitmap text renderer controller RTL.
`ifndef BITMAP_TEXT_RENDERER_MACROS_SVH
`define BITMAP_TEXT_RENDERER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define BTR_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define BTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/btr_pkg.sv
// Types and constants shared by the bitmap text renderer modules.
`default_nettype none

package btr_pkg;

    localparam int GADDR_W     = 11;
    localparam int REM_W       = 12;
    localparam int MOD_STEPS   = 3;
    localparam int MOD_CNT_W   = 2;
    localparam int RECIP_SHIFT = 22;
    localparam int PROD_W      = GADDR_W + RECIP_SHIFT;
    localparam int BYTE_W      = 8;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 3;
    localparam int FW_W        = 4;
    localparam int ADV_W       = 8;
    localparam int SCALE_W     = 8;
    localparam int COORD_W     = 16;
    localparam int COLOR_W     = 16;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_DATA_W   = 112;
    localparam int OUT_DATA_W  = 64;

    localparam logic [CFG_ADDR_W-1:0] CFG_FONT_WIDTH = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_X_ADVANCE  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_Y_ADVANCE  = 2'd2;

    localparam logic [FW_W-1:0]  FONT_WIDTH_RST = 4'd6;
    localparam logic [ADV_W-1:0] X_ADVANCE_RST  = 8'd6;
    localparam logic [ADV_W-1:0] Y_ADVANCE_RST  = 8'd8;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    localparam logic [MOD_CNT_W-1:0] MOD_LAST = MOD_CNT_W'(MOD_STEPS - 1);
    localparam logic [ROW_W-1:0]     ROW_LAST = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_FETCH,
        ST_EMIT,
        ST_ADV_X,
        ST_ADV_Y
    } btr_state_t;

    typedef struct packed {
        logic start_draw;
        logic write_glyph;
        logic mod_step;
        logic fetch;
        logic emit;
        logic first_row;
        logic last_row;
        logic last_col;
        logic adv_x;
        logic adv_y;
    } btr_cmd_t;

    typedef struct packed {
        logic [FW_W-1:0] width;
        logic            out_free;
    } btr_status_t;

endpackage

`default_nettype wire

>>> rtl/btr_ctrl.sv
// Sequencer for the bitmap text renderer: request intake, address reduction, cell walk, cursor.
`default_nettype none

`include "bitmap_text_renderer_macros.svh"

module btr_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    input  wire logic                s_cmd,
    output logic                     s_tready,
    input  wire btr_pkg::btr_status_t sts,
    output btr_pkg::btr_cmd_t        ctl
);
    import btr_pkg::*;

    btr_state_t             state_reg, state_next;
    logic [MOD_CNT_W-1:0]   mod_cnt_reg, mod_cnt_next;
    logic [COL_W-1:0]       col_reg, col_next;
    logic [ROW_W-1:0]       row_reg, row_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            mod_cnt_reg <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            mod_cnt_reg <= mod_cnt_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        mod_cnt_next = mod_cnt_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        ctl          = '0;
        s_tready     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_cmd == CMD_DRAW)
                    begin
                        ctl.start_draw = 1'b1;
                        mod_cnt_next   = '0;
                        state_next     = ST_MOD;
                    end
                    else
                    begin
                        ctl.write_glyph = 1'b1;
                    end
                end
            end
            ST_MOD:
            begin
                ctl.mod_step = 1'b1;
                if (mod_cnt_reg == MOD_LAST)
                begin
                    // A zero-width font draws nothing but still moves the cursor.
                    state_next = (sts.width == '0) ? ST_ADV_X : ST_FETCH;
                end
                else
                begin
                    mod_cnt_next = mod_cnt_reg + 1'b1;
                end
            end
            ST_FETCH:
            begin
                ctl.fetch  = 1'b1;
                col_next   = '0;
                row_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                ctl.first_row = (row_reg == '0);
                ctl.last_row  = (row_reg == ROW_LAST);
                ctl.last_col  = ({1'b0, col_reg} == (sts.width - 1'b1));
                if (sts.out_free)
                begin
                    ctl.emit = 1'b1;
                    if (ctl.last_row)
                    begin
                        row_next = '0;
                        if (ctl.last_col)
                        begin
                            state_next = ST_ADV_X;
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            ST_ADV_X:
            begin
                ctl.adv_x  = 1'b1;
                state_next = ST_ADV_Y;
            end
            ST_ADV_Y:
            begin
                ctl.adv_y  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `BTR_ASSERT_IMP(a_emit_has_room, ctl.emit, sts.out_free, "cell issued into a full output register")
    `BTR_ASSERT_NEXT(a_last_cell_advances, ctl.emit && ctl.last_row && ctl.last_col, state_reg == ST_ADV_X, "last cell did not lead to cursor advance")
    `BTR_ASSERT_IMP(a_mod_count_bound, state_reg == ST_MOD, mod_cnt_reg <= MOD_LAST, "address reduction ran past its last step")

endmodule

`default_nettype wire

>>> rtl/btr_datapath.sv
// Datapath of the bitmap text renderer: glyph store, config registers, cursor and cell output.
`default_nettype none

module btr_datapath #(
    parameter int GLYPH_COUNT   = 256,
    parameter int MAX_WIDTH     = 8,
    parameter int SCREEN_WIDTH  = 384,
    parameter int SCREEN_HEIGHT = 216
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic [btr_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic [btr_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                 m_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic                            cfg_we,
    input  wire logic [btr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [btr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  wire btr_pkg::btr_cmd_t               ctl,
    output btr_pkg::btr_status_t                 sts
);
    import btr_pkg::*;

    localparam int DEPTH  = GLYPH_COUNT * MAX_WIDTH;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [REM_W-1:0]   DEPTH_L = REM_W'(DEPTH);
    localparam logic [FW_W-1:0]    MAXW_L  = FW_W'(MAX_WIDTH);
    localparam logic [RECIP_SHIFT:0] RECIP_L = (RECIP_SHIFT + 1)'((1 << RECIP_SHIFT) / DEPTH);
    localparam logic signed [COORD_W:0] SCR_W_L = (COORD_W + 1)'(SCREEN_WIDTH);
    localparam logic signed [COORD_W:0] SCR_H_L = (COORD_W + 1)'(SCREEN_HEIGHT);

    // Request fields.
    logic [GADDR_W-1:0] in_glyph_addr;
    logic [BYTE_W-1:0]  in_glyph_byte;
    logic [BYTE_W-1:0]  in_char_code;
    logic               in_new_string;
    logic [COORD_W-1:0] in_start_x, in_start_y;
    logic [COLOR_W-1:0] in_fg, in_bg;
    logic [SCALE_W-1:0] in_scale_x, in_scale_y;

    assign in_glyph_addr = s_tdata[10:0];
    assign in_glyph_byte = s_tdata[18:11];
    assign in_char_code  = s_tdata[26:19];
    assign in_new_string = s_tdata[27];
    assign in_start_x    = s_tdata[43:28];
    assign in_start_y    = s_tdata[59:44];
    assign in_fg         = s_tdata[75:60];
    assign in_bg         = s_tdata[91:76];
    assign in_scale_x    = s_tdata[99:92];
    assign in_scale_y    = s_tdata[107:100];

    logic [FW_W-1:0]    font_width_reg;
    logic [ADV_W-1:0]   x_advance_reg, y_advance_reg;
    logic [FW_W-1:0]    width;

    logic [COORD_W-1:0] cursor_x_reg, cursor_y_reg;
    logic               wrap_reg;

    logic [BYTE_W-1:0]  glyph_mem [DEPTH];
    logic [BYTE_W-1:0]  rd_data_reg;
    logic [ADDR_W-1:0]  addr_reg, addr_next, addr_inc;
    logic [REM_W-1:0]   addr_plus;

    logic [GADDR_W-1:0] dividend_reg;
    logic [GADDR_W-1:0] quot_reg;
    logic [PROD_W-1:0]  prod_full;
    logic [REM_W-1:0]   est_reg, est_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [REM_W-1:0]   lin_addr;

    logic [COLOR_W-1:0] fg_reg, bg_reg;
    logic [SCALE_W-1:0] scale_x_reg, scale_y_reg;
    logic [COORD_W-1:0] xprod_reg, yprod_reg;
    logic [COORD_W-1:0] col_x_reg, row_y_reg;
    logic [BYTE_W-1:0]  bits_reg;
    logic               cell_bit;

    logic [COORD_W-1:0] sum_x, sum_y;

    logic               out_valid_reg;
    logic [COORD_W-1:0] out_x_reg, out_y_reg;
    logic [SCALE_W-1:0] out_w_reg, out_h_reg;
    logic [COLOR_W-1:0] out_color_reg;
    logic               out_last_reg;

    assign width = (font_width_reg > MAXW_L) ? MAXW_L : font_width_reg;

    assign sts.width    = width;
    assign sts.out_free = !out_valid_reg || m_tready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_width_reg <= FONT_WIDTH_RST;
            x_advance_reg  <= X_ADVANCE_RST;
            y_advance_reg  <= Y_ADVANCE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_FONT_WIDTH: font_width_reg <= cfg_wdata[FW_W-1:0];
                CFG_X_ADVANCE:  x_advance_reg  <= cfg_wdata;
                CFG_Y_ADVANCE:  y_advance_reg  <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // Glyph store; the read port follows the address register's next value.
    assign addr_plus = REM_W'(addr_reg) + 1'b1;
    assign addr_inc  = (addr_plus == DEPTH_L) ? '0 : addr_plus[ADDR_W-1:0];

    always_comb
    begin
        addr_next = addr_reg;
        if (ctl.fetch)
        begin
            addr_next = rem_reg[ADDR_W-1:0];
        end
        else if (ctl.emit && ctl.first_row)
        begin
            addr_next = addr_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.write_glyph && ({1'b0, in_glyph_addr} < DEPTH_L))
        begin
            glyph_mem[in_glyph_addr[ADDR_W-1:0]] <= in_glyph_byte;
        end
        rd_data_reg <= glyph_mem[addr_next];
        addr_reg    <= addr_next;
    end

    // Remainder of char_code * width by the store depth. A reciprocal estimate of the
    // quotient is low by at most one, so a single compare and subtract finishes it.
    // The three registers settle one after another over three reduction steps.
    assign lin_addr  = REM_W'(in_char_code) * REM_W'(width);
    assign prod_full = PROD_W'(dividend_reg) * PROD_W'(RECIP_L);
    assign est_next  = REM_W'(dividend_reg) - REM_W'(quot_reg) * DEPTH_L;
    assign rem_next  = (est_reg >= DEPTH_L) ? (est_reg - DEPTH_L) : est_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.start_draw)
        begin
            dividend_reg <= lin_addr[GADDR_W-1:0];
        end
        else if (ctl.mod_step)
        begin
            quot_reg <= GADDR_W'(prod_full >> RECIP_SHIFT);
            est_reg  <= est_next;
            rem_reg  <= rem_next;
        end
    end

    // Per-character attributes and cell walk.
    assign cell_bit = ctl.first_row ? rd_data_reg[0] : bits_reg[0];

    always_ff @(posedge clk)
    begin
        if (ctl.start_draw)
        begin
            fg_reg      <= in_fg;
            bg_reg      <= in_bg;
            scale_x_reg <= in_scale_x;
            scale_y_reg <= in_scale_y;
            xprod_reg   <= COORD_W'(x_advance_reg) * COORD_W'(in_scale_x);
            yprod_reg   <= COORD_W'(y_advance_reg) * COORD_W'(in_scale_y);
        end
        if (ctl.fetch)
        begin
            col_x_reg <= cursor_x_reg;
            row_y_reg <= cursor_y_reg;
        end
        else if (ctl.emit)
        begin
            bits_reg <= ctl.first_row ? (rd_data_reg >> 1) : (bits_reg >> 1);
            if (ctl.last_row)
            begin
                row_y_reg <= cursor_y_reg;
                col_x_reg <= col_x_reg + COORD_W'(scale_x_reg);
            end
            else
            begin
                row_y_reg <= row_y_reg + COORD_W'(scale_y_reg);
            end
        end
    end

    // Cursor: load at string start, advance x after each character and y when x wraps.
    assign sum_x = cursor_x_reg + xprod_reg;
    assign sum_y = cursor_y_reg + yprod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            wrap_reg     <= 1'b0;
        end
        else if (ctl.start_draw && in_new_string)
        begin
            cursor_x_reg <= in_start_x;
            cursor_y_reg <= in_start_y;
        end
        else if (ctl.adv_x)
        begin
            if ($signed({sum_x[COORD_W-1], sum_x}) >= SCR_W_L)
            begin
                cursor_x_reg <= '0;
                wrap_reg     <= 1'b1;
            end
            else
            begin
                cursor_x_reg <= sum_x;
                wrap_reg     <= 1'b0;
            end
        end
        else if (ctl.adv_y && wrap_reg)
        begin
            if ($signed({sum_y[COORD_W-1], sum_y}) >= SCR_H_L)
            begin
                cursor_y_reg <= '0;
            end
            else
            begin
                cursor_y_reg <= sum_y;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            out_x_reg     <= col_x_reg;
            out_y_reg     <= row_y_reg;
            out_w_reg     <= scale_x_reg;
            out_h_reg     <= scale_y_reg;
            out_color_reg <= cell_bit ? fg_reg : bg_reg;
            out_last_reg  <= ctl.last_row && ctl.last_col;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_color_reg, out_h_reg, out_w_reg, out_y_reg, out_x_reg};

endmodule

`default_nettype wire

>>> rtl/bitmap_text_renderer.sv
// A load request writes its glyph byte; a draw request runs the 3-step address reduction, the fetch,
// the cell walk over 8*W cells (W = font width, capped at MAX_WIDTH) and the cursor advance,
// and no new request is taken until it is done. Cells leave the glyph store at one cell per cycle
// while the output register has room; output stalls hold the walk. A zero-width font skips the walk.
// Reset clears the cursor and control state and loads register defaults (6, 6, 8).
// The glyph store is not cleared by reset and must be loaded before use.
`default_nettype none

module bitmap_text_renderer #(
    parameter int GLYPH_COUNT   = 256,
    parameter int MAX_WIDTH     = 8,
    parameter int SCREEN_WIDTH  = 384,
    parameter int SCREEN_HEIGHT = 216
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // glyph_addr, glyph_byte, char_code, new_string, start_x, start_y, fg_color,
    // bg_color, scale_x, scale_y, zero pad
    input  wire logic [btr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // cmd
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // rect_x, rect_y, rect_w, rect_h, cell_color
    output logic [btr_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    output logic                                 m_axis_tlast,
    input  wire logic                            cfg_we,
    input  wire logic [btr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [btr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import btr_pkg::*;

    btr_cmd_t    ctl;
    btr_status_t sts;

    btr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_cmd    (s_axis_tuser),
        .s_tready (s_axis_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    btr_datapath #(
        .GLYPH_COUNT   (GLYPH_COUNT),
        .MAX_WIDTH     (MAX_WIDTH),
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_axis_tdata),
        .m_tdata   (m_axis_tdata),
        .m_tlast   (m_axis_tlast),
        .m_tvalid  (m_axis_tvalid),
        .m_tready  (m_axis_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

`default_nettype wire
